FILE: rtl/ppm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Peak-to-peak level meter package
// Shared types, command codes, register indexes and fixed constants.
// ----------------------------------------------------------------------------
package ppm_pkg;

	// Field and register widths fixed by the interface.
	localparam int CMD_W       = 2;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 16;
	localparam int DIVISOR_W   = 8;
	localparam int SENS_W      = 8;
	localparam int DECAY_W     = 16;
	localparam int LEVEL_W     = 8;
	localparam int HEIGHT_W    = 4;

	// Input command codes.
	localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd0;
	localparam logic [CMD_W-1:0] CMD_TICK   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] REG_DIVISOR     = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_SENSITIVITY = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_DECAY       = 2'd2;

	// Register reset values.
	localparam logic [DIVISOR_W-1:0] DIVISOR_RESET = 8'd3;
	localparam logic [SENS_W-1:0]    SENS_RESET    = 8'd10;
	localparam logic [DECAY_W-1:0]   DECAY_RESET   = 16'd100;

	// Level clamp and full-scale point of the bar.
	localparam logic [LEVEL_W-1:0] LEVEL_MAX        = 8'd250;
	localparam logic [LEVEL_W-1:0] LEVEL_FULL_SCALE = 8'd125;

	// Division by the full-scale point as a multiply by a reciprocal.
	// Exact for products below 2048, which covers every height below full scale.
	localparam int SCALE_SHIFT = 18;
	localparam int SCALE_RECIP = 2098;

	// Controller states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIVIDE,
		ST_LEVEL,
		ST_SCALE
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic take;       // an input word is accepted this cycle
		logic div_start;  // window closes: load the dividers
		logic div_step;   // one restoring division step
		logic level_en;   // form the amplitude from the quotients
		logic scale_en;   // form the target height
		logic out_load;   // load the output register
	} ctrl_cmd_t;

endpackage
`default_nettype wire

FILE: rtl/ppm_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Peak-to-peak level meter controller
// Sequences the window close and owns the input and output handshakes.
// ----------------------------------------------------------------------------
module ppm_ctrl (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_stall,
	input  wire logic [ppm_pkg::CMD_W-1:0] cmd,
	input  wire logic                     window_end,
	output logic                          out_valid,
	input  wire logic                     out_stall,
	input  wire logic                     div_last,
	output ppm_pkg::ctrl_cmd_t            ctl
);

	ppm_pkg::state_t state_q;
	ppm_pkg::state_t state_n;
	logic            out_valid_q;
	logic            close_req;

	assign close_req = (cmd == ppm_pkg::CMD_SAMPLE) && window_end;
	assign out_valid = out_valid_q;

	// Output decode.
	always_comb begin
		in_stall      = (state_q != ppm_pkg::ST_IDLE) || (out_valid_q && out_stall);
		ctl.take      = in_valid && !in_stall;
		ctl.div_start = ctl.take && close_req;
		ctl.div_step  = (state_q == ppm_pkg::ST_DIVIDE);
		ctl.level_en  = (state_q == ppm_pkg::ST_LEVEL);
		ctl.scale_en  = (state_q == ppm_pkg::ST_SCALE);
		ctl.out_load  = (ctl.take && !close_req) || ctl.scale_en;
	end

	// Next state.
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ppm_pkg::ST_IDLE: begin
				if (ctl.div_start)
					state_n = ppm_pkg::ST_DIVIDE;
			end
			ppm_pkg::ST_DIVIDE: begin
				if (div_last)
					state_n = ppm_pkg::ST_LEVEL;
			end
			ppm_pkg::ST_LEVEL: begin
				state_n = ppm_pkg::ST_SCALE;
			end
			ppm_pkg::ST_SCALE: begin
				state_n = ppm_pkg::ST_IDLE;
			end
			default: begin
				state_n = ppm_pkg::ST_IDLE;
			end
		endcase
	end

	// State and output word flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ppm_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (ctl.out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	// A new result is only written when the output register is free or draining.
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.out_load |-> (!out_valid_q || !out_stall))
		else $error("output register overwritten while stalled");

	// A window-closing word always starts the divider sequence.
	a_close_seq: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.div_start |=> (state_q == ppm_pkg::ST_DIVIDE))
		else $error("window close did not start division");

	// The scale step always leaves a result waiting.
	a_scale_out: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.scale_en |=> out_valid_q)
		else $error("window result not presented");

endmodule
`default_nettype wire

FILE: rtl/ppm_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Peak-to-peak level meter datapath
// Window tracking, two serial dividers, amplitude, bar state and output register.
// ----------------------------------------------------------------------------
module ppm_dp #(
	parameter int BAR_SEGMENTS = 8,
	parameter int SAMPLE_WIDTH = 12
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [ppm_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [ppm_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire logic [ppm_pkg::CMD_W-1:0]       cmd,
	input  wire logic [SAMPLE_WIDTH-1:0]         sample_value,
	input  wire ppm_pkg::ctrl_cmd_t              ctl,
	output logic                                div_last,
	output logic [ppm_pkg::HEIGHT_W-1:0]         bar_height,
	output logic [ppm_pkg::LEVEL_W-1:0]          level,
	output logic [ppm_pkg::LEVEL_W-1:0]          peak_level,
	output logic                                bar_changed
);

	localparam int CNT_W   = $clog2(SAMPLE_WIDTH);
	localparam int DW      = ppm_pkg::DIVISOR_W;
	localparam int SCALE_K = BAR_SEGMENTS * ppm_pkg::SCALE_RECIP;
	localparam int PROD_W  = ppm_pkg::SCALE_SHIFT + ppm_pkg::HEIGHT_W + 1;
	localparam logic [ppm_pkg::HEIGHT_W-1:0] BAR_MAX = ppm_pkg::HEIGHT_W'(BAR_SEGMENTS);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SAMPLE_WIDTH - 1);

	// Configuration registers.
	logic [DW-1:0]                divisor_q;
	logic [ppm_pkg::SENS_W-1:0]   sens_q;
	logic [ppm_pkg::DECAY_W-1:0]  decay_q;

	// Meter state.
	logic [SAMPLE_WIDTH-1:0]        hi_q, lo_q, hi_n, lo_n;
	logic [ppm_pkg::LEVEL_W-1:0]    last_level_q;
	logic [ppm_pkg::LEVEL_W-1:0]    record_q, record_n;
	logic [ppm_pkg::HEIGHT_W-1:0]   target_q;
	logic [ppm_pkg::HEIGHT_W-1:0]   shown_q, shown_n;
	logic                           dark_q, dark_n;
	logic [ppm_pkg::DECAY_W-1:0]    ms_q, ms_n;
	logic                           changed_n;

	// Divider lanes: lane 0 divides the maximum, lane 1 the minimum.
	logic [DW-1:0]           rem_q [2];
	logic [SAMPLE_WIDTH-1:0] quo_q [2];
	logic [DW-1:0]           rem_n [2];
	logic [SAMPLE_WIDTH-1:0] quo_n [2];
	logic [CNT_W-1:0]        cnt_q;
	logic [DW-1:0]           dsr;

	// Amplitude and height.
	logic [SAMPLE_WIDTH-1:0]       p2p, amp_raw;
	logic [ppm_pkg::LEVEL_W-1:0]   amp;
	logic [PROD_W-1:0]             prod;
	logic [ppm_pkg::HEIGHT_W-1:0]  height;

	// Output register.
	logic [ppm_pkg::HEIGHT_W-1:0] bar_height_q;
	logic [ppm_pkg::LEVEL_W-1:0]  level_q;
	logic [ppm_pkg::LEVEL_W-1:0]  peak_q;
	logic                         changed_q;

	assign bar_height  = bar_height_q;
	assign level       = level_q;
	assign peak_level  = peak_q;
	assign bar_changed = changed_q;
	assign div_last    = (cnt_q == CNT_LAST);

	// Update of the meter state for one accepted word.
	always_comb begin
		hi_n      = hi_q;
		lo_n      = lo_q;
		record_n  = record_q;
		shown_n   = shown_q;
		dark_n    = dark_q;
		ms_n      = ms_q;
		changed_n = 1'b0;
		if (ctl.take) begin
			case (cmd)
				ppm_pkg::CMD_SAMPLE: begin
					if (sample_value > hi_q)
						hi_n = sample_value;
					if (sample_value < lo_q)
						lo_n = sample_value;
				end
				ppm_pkg::CMD_TICK: begin
					if (target_q > shown_q) begin
						shown_n   = target_q;
						ms_n      = '0;
						dark_n    = 1'b0;
						changed_n = 1'b1;
					end else if (ms_q < decay_q) begin
						ms_n = ms_q + 1'b1;
					end else if (shown_q == '0) begin
						dark_n = 1'b1;
					end else begin
						shown_n = shown_q - 1'b1;
						if (!dark_q) begin
							ms_n      = '0;
							changed_n = 1'b1;
						end
					end
				end
				ppm_pkg::CMD_CLEAR: begin
					record_n = '0;
				end
				default: begin
				end
			endcase
		end
	end

	// One restoring division step per lane.
	assign dsr = (divisor_q == '0) ? DW'(1) : divisor_q;

	always_comb begin
		logic [DW:0] part;
		logic        ge;
		for (int i = 0; i < 2; i++) begin
			part     = {rem_q[i], quo_q[i][SAMPLE_WIDTH-1]};
			ge       = (part >= {1'b0, dsr});
			rem_n[i] = ge ? DW'(part - {1'b0, dsr}) : part[DW-1:0];
			quo_n[i] = {quo_q[i][SAMPLE_WIDTH-2:0], ge};
		end
	end

	// Amplitude from the two quotients, less the offset, clamped.
	always_comb begin
		p2p     = (quo_q[0] >= quo_q[1]) ? (quo_q[0] - quo_q[1]) : '0;
		amp_raw = (p2p > SAMPLE_WIDTH'(sens_q)) ? (p2p - SAMPLE_WIDTH'(sens_q)) : '0;
		amp     = (amp_raw > SAMPLE_WIDTH'(ppm_pkg::LEVEL_MAX)) ?
		          ppm_pkg::LEVEL_MAX : amp_raw[ppm_pkg::LEVEL_W-1:0];
	end

	// Target height: level * segments / full scale, capped at the bar length.
	always_comb begin
		prod   = PROD_W'(last_level_q) * PROD_W'(SCALE_K);
		height = (last_level_q >= ppm_pkg::LEVEL_FULL_SCALE) ?
		         BAR_MAX : prod[ppm_pkg::SCALE_SHIFT +: ppm_pkg::HEIGHT_W];
	end

	// Configuration and meter state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			divisor_q    <= ppm_pkg::DIVISOR_RESET;
			sens_q       <= ppm_pkg::SENS_RESET;
			decay_q      <= ppm_pkg::DECAY_RESET;
			hi_q         <= '0;
			lo_q         <= '1;
			last_level_q <= '0;
			record_q     <= '0;
			target_q     <= '0;
			shown_q      <= '0;
			dark_q       <= 1'b0;
			ms_q         <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					ppm_pkg::REG_DIVISOR:     divisor_q <= cfg_data[DW-1:0];
					ppm_pkg::REG_SENSITIVITY: sens_q    <= cfg_data[ppm_pkg::SENS_W-1:0];
					ppm_pkg::REG_DECAY:       decay_q   <= cfg_data[ppm_pkg::DECAY_W-1:0];
					default: begin
					end
				endcase
			end
			if (ctl.take) begin
				hi_q    <= ctl.div_start ? '0 : hi_n;
				lo_q    <= ctl.div_start ? '1 : lo_n;
				shown_q <= shown_n;
				dark_q  <= dark_n;
				ms_q    <= ms_n;
			end
			if (ctl.level_en) begin
				last_level_q <= amp;
				if (amp > record_q)
					record_q <= amp;
			end else if (ctl.take) begin
				record_q <= record_n;
			end
			if (ctl.scale_en)
				target_q <= height;
		end
	end

	// Divider lanes and step counter.
	always_ff @(posedge clk) begin
		if (ctl.div_start) begin
			rem_q[0] <= '0;
			rem_q[1] <= '0;
			quo_q[0] <= hi_n;
			quo_q[1] <= lo_n;
			cnt_q    <= '0;
		end else if (ctl.div_step) begin
			rem_q[0] <= rem_n[0];
			rem_q[1] <= rem_n[1];
			quo_q[0] <= quo_n[0];
			quo_q[1] <= quo_n[1];
			cnt_q    <= cnt_q + 1'b1;
		end
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			bar_height_q <= shown_n;
			level_q      <= last_level_q;
			peak_q       <= record_n;
			changed_q    <= changed_n;
		end
	end

	// The shown bar and the target never pass the bar length.
	a_bar_range: assert property (@(posedge clk) disable iff (!arst_n)
		(shown_q <= BAR_MAX) && (target_q <= BAR_MAX))
		else $error("bar height out of range");

	// Levels stay within the clamp.
	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		(last_level_q <= ppm_pkg::LEVEL_MAX) && (record_q <= ppm_pkg::LEVEL_MAX))
		else $error("level out of range");

	// A closed window raises the peak record to at least its level.
	a_record_follow: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.level_en |=> (record_q >= last_level_q))
		else $error("peak record below new level");

endmodule
`default_nettype wire

FILE: rtl/peak_to_peak_level_meter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Peak-to-peak level meter
// Tracks the window minimum and maximum of ADC samples, turns them into a
// clamped amplitude and drives a bar display with timed decay.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake            Word
//  input     in_valid / in_stall  cmd, sample_value, window_end
//  output    out_valid/out_stall  bar_height, level, peak_level, bar_changed
//  config    cfg_we               cfg_index, cfg_data
//
// Ticks, clears and samples that do not end a window load the output register
// in the cycle they are taken. A window-end sample runs the bit-serial restoring
// dividers on the maximum and minimum, then the level and scale steps.
// One word is in work at a time; a finished word waits in the output register
// and the next word is taken in the cycle that register drains.
// Reset is asynchronous and needs no clearing pass.
//
module peak_to_peak_level_meter #(
	parameter int BAR_SEGMENTS = 8,
	parameter int SAMPLE_WIDTH = 12
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic [ppm_pkg::CMD_W-1:0]       cmd,
	input  wire logic [SAMPLE_WIDTH-1:0]         sample_value,
	input  wire logic                           window_end,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic [ppm_pkg::HEIGHT_W-1:0]         bar_height,
	output logic [ppm_pkg::LEVEL_W-1:0]          level,
	output logic [ppm_pkg::LEVEL_W-1:0]          peak_level,
	output logic                                bar_changed,
	input  wire logic                           cfg_we,
	input  wire logic [ppm_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [ppm_pkg::CFG_DATA_W-1:0]  cfg_data
);

	ppm_pkg::ctrl_cmd_t ctl;
	logic               div_last;

	// Sequencer and handshakes.
	ppm_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.cmd        (cmd),
		.window_end (window_end),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.div_last   (div_last),
		.ctl        (ctl)
	);

	// Arithmetic, meter state and output register.
	ppm_dp #(
		.BAR_SEGMENTS (BAR_SEGMENTS),
		.SAMPLE_WIDTH (SAMPLE_WIDTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.cmd          (cmd),
		.sample_value (sample_value),
		.ctl          (ctl),
		.div_last     (div_last),
		.bar_height   (bar_height),
		.level        (level),
		.peak_level   (peak_level),
		.bar_changed  (bar_changed)
	);

endmodule
`default_nettype wire

FILE: verif/peak_to_peak_level_meter_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Peak-to-peak level meter checker
// Watches the input, output and register ports of the meter. It keeps its own
// copy of the window, level and bar state and works out the reading that each
// accepted word must produce. It then compares every delivered reading, field
// by field, with the oldest one still due.
// ----------------------------------------------------------------------------
module peak_to_peak_level_meter_checker
	import ppm_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic                   in_stall,
	input  logic [CMD_W-1:0]       cmd,
	input  logic [11:0]            sample_value,
	input  logic                   window_end,
	input  logic                   out_valid,
	input  logic                   out_stall,
	input  logic [HEIGHT_W-1:0]    bar_height,
	input  logic [LEVEL_W-1:0]     level,
	input  logic [LEVEL_W-1:0]     peak_level,
	input  logic                   bar_changed,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	output int                     fail_count,
	output int                     due_count,
	output int                     words_taken,
	output int                     readings_seen,
	output int                     windows_closed,
	output int                     redraws_seen
);

	localparam int SEGMENTS   = 8;
	localparam int SAMPLE_TOP = 4095;

	// One reading of the meter as it appears on the output port.
	typedef struct packed {
		logic [HEIGHT_W-1:0] bar;
		logic [LEVEL_W-1:0]  lvl;
		logic [LEVEL_W-1:0]  peak;
		logic                redraw;
	} reading_t;

	reading_t readings_due[$];

	// Register copies.
	logic [DIVISOR_W-1:0] divisor_q;
	logic [SENS_W-1:0]    sens_q;
	logic [DECAY_W-1:0]   decay_q;

	// Meter state.
	logic [11:0]         win_high;
	logic [11:0]         win_low;
	logic [LEVEL_W-1:0]  last_lvl;
	logic [LEVEL_W-1:0]  lvl_record;
	logic [HEIGHT_W-1:0] target_h;
	logic [HEIGHT_W-1:0] shown_h;
	logic                dark;
	logic [DECAY_W-1:0]  ms_count;

	int fails    = 0;
	int due      = 0;
	int taken    = 0;
	int seen     = 0;
	int closed   = 0;
	int redraws  = 0;

	assign fail_count     = fails;
	assign due_count      = due;
	assign words_taken    = taken;
	assign readings_seen  = seen;
	assign windows_closed = closed;
	assign redraws_seen   = redraws;

	task automatic report_mismatch(input string msg);
		$display("[%0t] MISMATCH: %s", $realtime, msg);
		fails++;
	endtask

	// Applies one word to the meter state and returns the reading it yields.
	function automatic reading_t advance_meter(input logic [CMD_W-1:0] c,
			input logic [11:0] s, input logic last);
		reading_t r;
		int d;
		int hi;
		int lo;
		int p2p;
		int amp;
		int h;
		logic redraw;
		redraw = 1'b0;
		case (c)
			CMD_SAMPLE: begin
				// Minimum and maximum are tracked independently.
				if (s > win_high)
					win_high = s;
				if (s < win_low)
					win_low = s;
				if (last) begin
					// A zero divisor acts as one.
					d   = (divisor_q == 0) ? 1 : int'(divisor_q);
					hi  = int'(win_high) / d;
					lo  = int'(win_low) / d;
					p2p = (hi >= lo) ? hi - lo : 0;
					amp = (p2p > int'(sens_q)) ? p2p - int'(sens_q) : 0;
					if (amp > int'(LEVEL_MAX))
						amp = int'(LEVEL_MAX);
					last_lvl = amp[LEVEL_W-1:0];
					if (amp > int'(lvl_record))
						lvl_record = amp[LEVEL_W-1:0];
					h = amp * SEGMENTS / int'(LEVEL_FULL_SCALE);
					if (h > SEGMENTS)
						h = SEGMENTS;
					target_h = h[HEIGHT_W-1:0];
					win_high = '0;
					win_low  = 12'(SAMPLE_TOP);
					closed++;
				end
			end
			CMD_TICK: begin
				// Rise at once; otherwise count toward the next drop.
				if (target_h > shown_h) begin
					shown_h  = target_h;
					ms_count = '0;
					dark     = 1'b0;
					redraw   = 1'b1;
				end else if (ms_count < decay_q) begin
					ms_count = ms_count + 1'b1;
				end else if (shown_h == 0) begin
					// One interval after reaching zero the bar goes dark.
					dark = 1'b1;
				end else begin
					shown_h = shown_h - 1'b1;
					if (!dark) begin
						ms_count = '0;
						redraw   = 1'b1;
					end
				end
			end
			CMD_CLEAR: begin
				lvl_record = '0;
			end
			default: begin
			end
		endcase
		r.bar    = shown_h;
		r.lvl    = last_lvl;
		r.peak   = lvl_record;
		r.redraw = redraw;
		return r;
	endfunction

	// Register writes, output comparison and prediction, in that order, so a
	// reading leaving at an edge is never matched against the word entering.
	always @(posedge clk or negedge arst_n) begin
		reading_t want;
		if (!arst_n) begin
			divisor_q  = DIVISOR_RESET;
			sens_q     = SENS_RESET;
			decay_q    = DECAY_RESET;
			win_high   = '0;
			win_low    = 12'(SAMPLE_TOP);
			last_lvl   = '0;
			lvl_record = '0;
			target_h   = '0;
			shown_h    = '0;
			dark       = 1'b0;
			ms_count   = '0;
			readings_due.delete();
			due = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_DIVISOR:     divisor_q = cfg_data[DIVISOR_W-1:0];
					REG_SENSITIVITY: sens_q    = cfg_data[SENS_W-1:0];
					REG_DECAY:       decay_q   = cfg_data[DECAY_W-1:0];
					default: begin
					end
				endcase
			end
			if (out_valid && !out_stall) begin
				seen++;
				if (bar_changed)
					redraws++;
				if (readings_due.size() == 0) begin
					report_mismatch("reading delivered with none due");
				end else begin
					want = readings_due.pop_front();
					if (bar_height !== want.bar)
						report_mismatch($sformatf("bar_height got %0d, expected %0d",
							bar_height, want.bar));
					if (level !== want.lvl)
						report_mismatch($sformatf("level got %0d, expected %0d",
							level, want.lvl));
					if (peak_level !== want.peak)
						report_mismatch($sformatf("peak_level got %0d, expected %0d",
							peak_level, want.peak));
					if (bar_changed !== want.redraw)
						report_mismatch($sformatf("bar_changed got %0b, expected %0b",
							bar_changed, want.redraw));
				end
			end
			if (in_valid && !in_stall) begin
				readings_due.push_back(advance_meter(cmd, sample_value, window_end));
				taken++;
			end
			due = readings_due.size();
		end
	end

endmodule

FILE: verif/peak_to_peak_level_meter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Peak-to-peak level meter testbench
// Drives samples, millisecond ticks, clears and unused commands into the
// meter under a series of register settings, with random gaps on the input
// and random stalls on the output, and lets the checker judge each reading.
// ----------------------------------------------------------------------------
module peak_to_peak_level_meter_tb;
	import ppm_pkg::*;

	localparam logic [CMD_W-1:0]       CMD_UNUSED = 2'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_NONE   = 2'd3;
	localparam int HOLD_CYCLES = 64;

	logic                   clk;
	logic                   arst_n;
	logic                   in_valid;
	logic                   in_stall;
	logic [CMD_W-1:0]       cmd;
	logic [11:0]            sample_value;
	logic                   window_end;
	logic                   out_valid;
	logic                   out_stall;
	logic [HEIGHT_W-1:0]    bar_height;
	logic [LEVEL_W-1:0]     level;
	logic [LEVEL_W-1:0]     peak_level;
	logic                   bar_changed;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	int fail_count;
	int due_count;
	int words_taken;
	int readings_seen;
	int windows_closed;
	int redraws_seen;

	// Shared between the sender and the receiver; settings_used counts register settings.
	logic quiet;
	int   hold_asked;
	int   settings_used;

	// Current measurement window shape for random samples.
	int win_base;
	int win_span;

	peak_to_peak_level_meter dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.cmd          (cmd),
		.sample_value (sample_value),
		.window_end   (window_end),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.bar_height   (bar_height),
		.level        (level),
		.peak_level   (peak_level),
		.bar_changed  (bar_changed),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	peak_to_peak_level_meter_checker meter_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.cmd            (cmd),
		.sample_value   (sample_value),
		.window_end     (window_end),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.bar_height     (bar_height),
		.level          (level),
		.peak_level     (peak_level),
		.bar_changed    (bar_changed),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.fail_count     (fail_count),
		.due_count      (due_count),
		.words_taken    (words_taken),
		.readings_seen  (readings_seen),
		.windows_closed (windows_closed),
		.redraws_seen   (redraws_seen)
	);

	// 100 MHz clock.
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Receiver: random stall bursts, a long hold-off on request, none when quiet.
	initial begin
		int stall_left;
		int hold_seen;
		stall_left = 0;
		hold_seen  = 0;
		out_stall  = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_seen != hold_asked) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				hold_seen++;
			end else begin
				if (!quiet && stall_left == 0 && $urandom_range(0, 7) == 0)
					stall_left = $urandom_range(1, 9);
				if (quiet)
					stall_left = 0;
				if (stall_left > 0) begin
					out_stall <= 1'b1;
					stall_left--;
				end else begin
					out_stall <= 1'b0;
				end
			end
		end
	end

	// Offers one word, after an optional idle burst, and waits until it is taken.
	task automatic send_word(input logic [CMD_W-1:0] c, input logic [11:0] s,
			input logic last);
		int gap;
		gap = 0;
		if (!quiet && $urandom_range(0, 5) == 0)
			gap = $urandom_range(1, 9);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid     <= 1'b1;
		cmd          <= c;
		sample_value <= s;
		window_end   <= last;
		do
			@(posedge clk);
		while (in_stall);
	endtask

	// Stops offering words and waits until every reading has come out.
	task automatic drain_readings();
		@(negedge clk);
		in_valid <= 1'b0;
		while (due_count != 0)
			@(negedge clk);
	endtask

	// Writes all three registers while the meter is idle; optionally also
	// pokes the unused index, which must have no effect.
	task automatic write_registers(input logic [7:0] div, input logic [7:0] sens,
			input logic [15:0] decay, input logic poke_unused);
		drain_readings();
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= REG_DIVISOR;
		cfg_data  <= {8'($urandom), div};
		@(negedge clk);
		cfg_index <= REG_SENSITIVITY;
		cfg_data  <= {8'($urandom), sens};
		@(negedge clk);
		cfg_index <= REG_DECAY;
		cfg_data  <= decay;
		if (poke_unused) begin
			@(negedge clk);
			cfg_index <= REG_NONE;
			cfg_data  <= 16'($urandom);
		end
		@(negedge clk);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	// Random words: mostly windows of clustered samples mixed with ticks,
	// plus clears and unused commands as noise.
	task automatic send_random_words(input int count, input int hold_at);
		int r;
		int s;
		logic last;
		for (int i = 0; i < count; i++) begin
			if (i == hold_at)
				hold_asked++;
			r = $urandom_range(0, 99);
			if (r < 48) begin
				if ($urandom_range(0, 3) == 0)
					s = $urandom_range(0, 4095);
				else
					s = win_base + $urandom_range(0, win_span);
				if (s > 4095)
					s = 4095;
				last = ($urandom_range(0, 6) == 0);
				send_word(CMD_SAMPLE, 12'(s), last);
				if (last) begin
					win_span = (1 << $urandom_range(0, 12)) - 1;
					win_base = $urandom_range(0, 4095 - win_span);
				end
			end else if (r < 92) begin
				send_word(CMD_TICK, 12'($urandom), 1'($urandom));
			end else if (r < 96) begin
				send_word(CMD_CLEAR, 12'($urandom), 1'($urandom));
			end else begin
				send_word(CMD_UNUSED, 12'($urandom), 1'($urandom));
			end
		end
	endtask

	// Stimulus and verdict.
	initial begin
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		cmd           = CMD_SAMPLE;
		sample_value  = '0;
		window_end    = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = REG_DIVISOR;
		cfg_data      = '0;
		quiet         = 1'b0;
		hold_asked    = 0;
		settings_used = 1;
		win_base      = 0;
		win_span      = 4095;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed words under the reset register values.
		send_word(CMD_TICK,   12'd0,    1'b0);
		send_word(CMD_SAMPLE, 12'd4095, 1'b0);
		send_word(CMD_SAMPLE, 12'd0,    1'b1);   // full-scale window, clamps
		send_word(CMD_TICK,   12'd4095, 1'b1);   // rise; window_end ignored
		send_word(CMD_CLEAR,  12'd4095, 1'b1);   // clears only the record
		send_word(CMD_UNUSED, 12'd4095, 1'b1);   // unused command is ignored
		send_word(CMD_SAMPLE, 12'd2048, 1'b1);   // one sample sets min and max
		send_word(CMD_SAMPLE, 12'd0,    1'b1);
		send_word(CMD_SAMPLE, 12'd4095, 1'b1);
		send_word(CMD_SAMPLE, 12'd100,  1'b0);
		send_word(CMD_SAMPLE, 12'd40,   1'b1);   // amplitude of 10 after the offset
		send_word(CMD_SAMPLE, 12'd390,  1'b0);
		send_word(CMD_SAMPLE, 12'd0,    1'b1);   // bar height of 7, just below full scale
		send_word(CMD_TICK,   12'd0,    1'b0);
		send_word(CMD_SAMPLE, 12'd1000, 1'b0);
		send_word(CMD_SAMPLE, 12'd3000, 1'b1);
		send_word(CMD_TICK,   12'd0,    1'b0);
		send_word(CMD_CLEAR,  12'd0,    1'b0);
		send_word(CMD_TICK,   12'd0,    1'b0);
		send_word(CMD_UNUSED, 12'd0,    1'b0);
		send_random_words(100, -1);

		// Extreme settings, including a zero divisor and a zero decay interval.
		write_registers(8'd1, 8'd0, 16'd0, 1'b0);
		send_random_words(120, -1);
		write_registers(8'd255, 8'd255, 16'd65535, 1'b0);
		send_random_words(100, -1);
		write_registers(8'd0, 8'd0, 16'd1, 1'b1);
		send_random_words(120, 40);

		// Random moderate settings with short decay so the bar falls to dark.
		for (int k = 0; k < 4; k++) begin
			write_registers(8'($urandom_range(1, 16)), 8'($urandom_range(0, 30)),
				16'($urandom_range(0, 6)), 1'b0);
			send_random_words(120, -1);
		end

		// Closing stretch at full rate on both sides.
		write_registers(8'd2, 8'd3, 16'd2, 1'b0);
		quiet = 1'b1;
		send_random_words(100, -1);

		drain_readings();
		repeat (20) @(negedge clk);
		$display("Covered %0d words under %0d register settings: %0d windows closed, %0d bar redraws.",
			words_taken, settings_used, windows_closed, redraws_seen);
		$display("Checked %0d readings; %0d mismatches.", readings_seen, fail_count);
		if (fail_count == 0 && due_count == 0) begin
			$display("peak_to_peak_level_meter_tb passed");
		end else begin
			$display("peak_to_peak_level_meter_tb failed");
		end
		$finish;
	end

	// Watchdog.
	initial begin
		#2000000;
		$display("peak_to_peak_level_meter_tb failed");
		$finish;
	end

endmodule
